/* src/spt_pkg.sv */
// Shared constants and types for the stride prefetch table.
package spt_pkg;

  localparam int ENTRIES     = 16;
  localparam int ADDR_WIDTH  = 32;
  localparam int TAG_W       = 32;
  localparam int IN_ADDR_W   = 32;
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 5;
  localparam int STATE_W     = 2;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_TRAIN  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATE_W-1:0] {
    ST_INVALID  = 2'd0,
    ST_TRAINING = 2'd1,
    ST_ACTIVE   = 2'd2
  } status_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic                  hit;
    logic [IDX_W-1:0]      idx;
    logic [TAG_W-1:0]      pc;
    logic [ADDR_WIDTH-1:0] address;
  } item_t;

endpackage

/* src/spt_ifs.sv */
// Handshake channels for request and response beats of the stride prefetch table.
interface spt_req_if;
  logic                         valid;
  logic                         ready;
  logic [spt_pkg::OP_W-1:0]      op;
  logic [spt_pkg::TAG_W-1:0]     pc;
  logic [spt_pkg::IN_ADDR_W-1:0] address;

  modport source (output valid, output op, output pc, output address, input ready);
  modport sink   (input valid, input op, input pc, input address, output ready);
endinterface

interface spt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [spt_pkg::INDEX_W-1:0] entry_index;
  logic [spt_pkg::STATE_W-1:0] entry_state;
  logic                        allocated;

  modport source (output valid, output hit, output entry_index, output entry_state,
                  output allocated, input ready);
  modport sink   (input valid, input hit, input entry_index, input entry_state,
                  input allocated, output ready);
endinterface

/* src/spt_front.sv */
// Front end: accepts request beats and classifies them against the tag array.
module spt_front (
  input  logic                    clk,
  input  logic                    rst,
  spt_req_if.sink                 request,
  input  logic [spt_pkg::TAG_W-1:0] tags [spt_pkg::ENTRIES],
  input  spt_pkg::status_t        status [spt_pkg::ENTRIES],
  input  logic                    done,
  output logic                    push_valid,
  input  logic                    push_ready,
  output spt_pkg::item_t          push_item
);

  logic busy;
  logic accept;
  spt_pkg::op_t op;
  logic [spt_pkg::ENTRIES-1:0] match_mask;
  logic [spt_pkg::ENTRIES-1:0] inv_mask;
  logic [spt_pkg::ENTRIES-1:0] tr_mask;
  logic match_found;
  logic inv_found;
  logic tr_found;
  logic [spt_pkg::IDX_W-1:0] match_idx;
  logic [spt_pkg::IDX_W-1:0] inv_idx;
  logic [spt_pkg::IDX_W-1:0] tr_idx;

  // One item is in flight until the back has updated the table for it.
  assign request.ready = !busy && push_ready;
  assign accept        = request.valid && request.ready;
  assign op            = spt_pkg::op_t'(request.op);

  always_comb begin
    for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
      inv_mask[i] = (status[i] == spt_pkg::ST_INVALID);
      tr_mask[i]  = (status[i] == spt_pkg::ST_TRAINING);
      case (op)
        spt_pkg::OP_ALLOC:  match_mask[i] = (tags[i] == request.pc) &&
                                            (status[i] != spt_pkg::ST_INVALID);
        spt_pkg::OP_TRAIN:  match_mask[i] = (tags[i] == request.pc);
        spt_pkg::OP_SEARCH: match_mask[i] = (tags[i] == request.pc) &&
                                            (status[i] == spt_pkg::ST_ACTIVE);
        default:            match_mask[i] = 1'b0;
      endcase
    end
  end

  // Priority encoders: the lowest set bit wins.
  always_comb begin
    match_found = 1'b0;
    inv_found   = 1'b0;
    tr_found    = 1'b0;
    match_idx   = '0;
    inv_idx     = '0;
    tr_idx      = '0;
    for (int i = spt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match_mask[i]) begin
        match_found = 1'b1;
        match_idx   = spt_pkg::IDX_W'(i);
      end
      if (inv_mask[i]) begin
        inv_found = 1'b1;
        inv_idx   = spt_pkg::IDX_W'(i);
      end
      if (tr_mask[i]) begin
        tr_found = 1'b1;
        tr_idx   = spt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    push_valid        = accept;
    push_item.op      = op;
    push_item.pc      = request.pc;
    push_item.address = spt_pkg::ADDR_WIDTH'(request.address);
    push_item.hit     = match_found;
    if (match_found) begin
      push_item.idx = match_idx;
    end else if (op == spt_pkg::OP_ALLOC && inv_found) begin
      push_item.idx = inv_idx;
    end else if (op == spt_pkg::OP_ALLOC && tr_found) begin
      push_item.idx = tr_idx;
    end else begin
      push_item.idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule

/* src/spt_queue.sv */
// Short queue of classified items between the front and the back.
module spt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  spt_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output spt_pkg::item_t pop_item
);

  spt_pkg::item_t slots [spt_pkg::QUEUE_DEPTH];
  logic [spt_pkg::QPTR_W-1:0] wr_ptr;
  logic [spt_pkg::QPTR_W-1:0] rd_ptr;
  logic [spt_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != spt_pkg::QCNT_W'(spt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == spt_pkg::QPTR_W'(spt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == spt_pkg::QPTR_W'(spt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/spt_back.sv */
// Back end: holds the table, performs the read-modify-write and drives the response.
module spt_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  spt_pkg::item_t            pop_item,
  spt_rsp_if.source                 response,
  output logic [spt_pkg::TAG_W-1:0] tags [spt_pkg::ENTRIES],
  output spt_pkg::status_t          status [spt_pkg::ENTRIES],
  output logic                      done
);

  logic [spt_pkg::ADDR_WIDTH-1:0] last_addr [spt_pkg::ENTRIES];
  logic [spt_pkg::ADDR_WIDTH-1:0] stride [spt_pkg::ENTRIES];

  logic                           rsp_valid;
  logic                           rsp_hit;
  logic [spt_pkg::INDEX_W-1:0]    rsp_index;
  spt_pkg::status_t               rsp_state;
  logic                           rsp_alloc;

  logic                           hit_next;
  logic [spt_pkg::CNT_W-1:0]      index_next;
  spt_pkg::status_t               state_next;
  logic                           alloc_next;

  spt_pkg::status_t               cur_st;
  logic [spt_pkg::ADDR_WIDTH-1:0] cur_last;
  logic [spt_pkg::ADDR_WIDTH-1:0] cur_stride;
  logic [spt_pkg::ADDR_WIDTH-1:0] diff;
  logic                           same_stride;
  logic                           ent_wr;
  logic [spt_pkg::TAG_W-1:0]      new_tag;
  logic [spt_pkg::ADDR_WIDTH-1:0] new_last;
  logic [spt_pkg::ADDR_WIDTH-1:0] new_stride;
  spt_pkg::status_t               new_st;

  // The result register frees the queue as soon as the receiver takes its beat.
  assign pop_ready = !rsp_valid || response.ready;
  assign done      = pop_valid && pop_ready;

  assign cur_st      = status[pop_item.idx];
  assign cur_last    = last_addr[pop_item.idx];
  assign cur_stride  = stride[pop_item.idx];
  assign diff        = pop_item.address - cur_last;
  assign same_stride = (diff == cur_stride);

  always_comb begin
    hit_next   = 1'b0;
    index_next = spt_pkg::CNT_W'(spt_pkg::ENTRIES);
    state_next = spt_pkg::ST_INVALID;
    alloc_next = 1'b0;
    ent_wr     = 1'b0;
    new_tag    = tags[pop_item.idx];
    new_last   = cur_last;
    new_stride = cur_stride;
    new_st     = cur_st;
    case (pop_item.op)
      spt_pkg::OP_ALLOC: begin
        index_next = spt_pkg::CNT_W'(pop_item.idx);
        if (pop_item.hit) begin
          hit_next   = 1'b1;
          state_next = cur_st;
        end else begin
          ent_wr     = 1'b1;
          new_tag    = pop_item.pc;
          new_last   = pop_item.address;
          new_stride = '0;
          new_st     = spt_pkg::ST_TRAINING;
          state_next = spt_pkg::ST_TRAINING;
          alloc_next = 1'b1;
        end
      end
      spt_pkg::OP_TRAIN: begin
        if (pop_item.hit) begin
          hit_next   = 1'b1;
          index_next = spt_pkg::CNT_W'(pop_item.idx);
          if (cur_st != spt_pkg::ST_INVALID) begin
            ent_wr = 1'b1;
            if (same_stride) begin
              new_st   = spt_pkg::ST_ACTIVE;
              new_last = pop_item.address;
            end else if (cur_st == spt_pkg::ST_TRAINING) begin
              new_last   = pop_item.address;
              new_stride = diff;
            end else begin
              new_st = spt_pkg::ST_INVALID;
            end
          end
          state_next = new_st;
        end
      end
      spt_pkg::OP_SEARCH: begin
        if (pop_item.hit) begin
          hit_next   = 1'b1;
          index_next = spt_pkg::CNT_W'(pop_item.idx);
          state_next = spt_pkg::ST_ACTIVE;
        end
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
        tags[i]   <= '0;
        status[i] <= spt_pkg::ST_INVALID;
      end
    end else begin
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
      if (done && ent_wr) begin
        tags[pop_item.idx]   <= new_tag;
        status[pop_item.idx] <= new_st;
      end
    end
  end

  // Address and stride are only read for live entries, which allocation always writes.
  always_ff @(posedge clk) begin
    if (done && ent_wr) begin
      last_addr[pop_item.idx] <= new_last;
      stride[pop_item.idx]    <= new_stride;
    end
    if (done) begin
      rsp_hit   <= hit_next;
      rsp_index <= spt_pkg::INDEX_W'(index_next);
      rsp_state <= state_next;
      rsp_alloc <= alloc_next;
    end
  end

  assign response.valid       = rsp_valid;
  assign response.hit         = rsp_hit;
  assign response.entry_index = rsp_index;
  assign response.entry_state = rsp_state;
  assign response.allocated   = rsp_alloc;

endmodule

/* src/stride_prefetch_table.sv */
// Stride prefetch table: request beats (allocate, train, search) in, one response beat out each.
// The request channel carries op, pc and address; a beat is taken when valid and ready
// are both high. Every request produces exactly one response beat carrying hit,
// entry_index, entry_state and allocated, in request order.
// The front end compares pc against all tags in the cycle it takes the beat and
// queues the classified item; the back end pops it, reads the chosen entry, updates it
// and loads the response register, so a response passes the queue slot and then the
// response register. The front does not take a new request while one is in flight:
// it holds ready low until the back has written the table for that item, since
// the next classification must see that update.
// When the receiver stalls, the response register holds its beat; the front may still
// take one further request, which waits in the queue until the register frees, and
// ready then stays low.
// A synchronous reset on rst marks every entry invalid, clears all tags, empties the
// queue and drops the response valid; requests are accepted in the cycle after reset.
module stride_prefetch_table (
  input  logic      clk,
  input  logic      rst,
  spt_req_if.sink   request,
  spt_rsp_if.source response
);

  logic [spt_pkg::TAG_W-1:0] tags [spt_pkg::ENTRIES];
  spt_pkg::status_t          status [spt_pkg::ENTRIES];
  logic                      done;
  logic                      push_valid;
  logic                      push_ready;
  spt_pkg::item_t            push_item;
  logic                      pop_valid;
  logic                      pop_ready;
  spt_pkg::item_t            pop_item;

  spt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .tags       (tags),
    .status     (status),
    .done       (done),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  spt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  spt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .response  (response),
    .tags      (tags),
    .status    (status),
    .done      (done)
  );

  // A new beat is never classified while an older item still waits in the queue.
  a_no_stale_classify: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |-> !pop_valid)
    else $error("request accepted while an item is still queued");

  // Completing an item always leaves a response beat pending.
  a_done_gives_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> response.valid)
    else $error("table update without a response beat");

  // Reset drops any pending response.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !response.valid)
    else $error("response valid after reset");

  // An allocation that wrote a fresh entry always reports it as training.
  a_alloc_training: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.allocated) |->
      (response.entry_state == spt_pkg::ST_TRAINING && !response.hit))
    else $error("allocated beat with wrong status");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the stride prefetch table with a predicting scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    spt_pkg::op_t                  op;
    logic [spt_pkg::TAG_W-1:0]     pc;
    logic [spt_pkg::IN_ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic                        hit;
    logic [spt_pkg::INDEX_W-1:0] entry_index;
    logic [spt_pkg::STATE_W-1:0] entry_state;
    logic                        allocated;
  } reply_t;

  localparam int TARGET_ITEMS = 1200;
  localparam int POOL_SIZE    = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spt_req_if req_ch ();
  spt_rsp_if rsp_ch ();

  stride_prefetch_table dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch.sink),
    .response (rsp_ch.source)
  );

  // Shadow copy of the table, updated in request order as beats are accepted.
  logic [spt_pkg::TAG_W-1:0]      pf_tag    [spt_pkg::ENTRIES];
  logic [spt_pkg::ADDR_WIDTH-1:0] pf_last   [spt_pkg::ENTRIES];
  logic [spt_pkg::ADDR_WIDTH-1:0] pf_stride [spt_pkg::ENTRIES];
  spt_pkg::status_t               pf_status [spt_pkg::ENTRIES];

  request_t                  request_q[$];
  reply_t                    reply_q[$];
  logic [spt_pkg::TAG_W-1:0] pc_pool[POOL_SIZE];

  int errors = 0;
  int recv_count = 0;
  int send_wait, send_next, recv_wait, recv_next;
  bit send_calm, recv_calm;
  request_t beat;
  reply_t   got, want;
  int hold_left = 0;
  int hold_at = 250;
  logic hold_on = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic reply_t table_lookup(input spt_pkg::op_t op,
                                          input logic [spt_pkg::TAG_W-1:0] pc,
                                          input logic [spt_pkg::IN_ADDR_W-1:0] address);
    reply_t r;
    int hit_at, first_inv, first_tr, victim;
    logic [spt_pkg::ADDR_WIDTH-1:0] addr, diff;
    r.hit = 1'b0;
    r.entry_index = spt_pkg::INDEX_W'(spt_pkg::ENTRIES);
    r.entry_state = spt_pkg::ST_INVALID;
    r.allocated = 1'b0;
    addr = spt_pkg::ADDR_WIDTH'(address);
    hit_at = -1;
    first_inv = -1;
    first_tr = -1;
    case (op)
      spt_pkg::OP_ALLOC: begin
        for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
          if (hit_at < 0 && pf_tag[i] == pc && pf_status[i] != spt_pkg::ST_INVALID)
            hit_at = i;
          if (first_inv < 0 && pf_status[i] == spt_pkg::ST_INVALID) first_inv = i;
          if (first_tr < 0 && pf_status[i] == spt_pkg::ST_TRAINING) first_tr = i;
        end
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          r.entry_index = spt_pkg::INDEX_W'(hit_at);
          r.entry_state = pf_status[hit_at];
        end else begin
          victim = (first_inv >= 0) ? first_inv : ((first_tr >= 0) ? first_tr : 0);
          pf_tag[victim] = pc;
          pf_last[victim] = addr;
          pf_stride[victim] = '0;
          pf_status[victim] = spt_pkg::ST_TRAINING;
          r.entry_index = spt_pkg::INDEX_W'(victim);
          r.entry_state = spt_pkg::ST_TRAINING;
          r.allocated = 1'b1;
        end
      end
      spt_pkg::OP_TRAIN: begin
        // The first tag match is used even when that entry is invalid.
        for (int i = 0; i < spt_pkg::ENTRIES; i++)
          if (hit_at < 0 && pf_tag[i] == pc) hit_at = i;
        if (hit_at >= 0) begin
          if (pf_status[hit_at] != spt_pkg::ST_INVALID) begin
            diff = addr - pf_last[hit_at];
            if (pf_stride[hit_at] == diff) begin
              pf_status[hit_at] = spt_pkg::ST_ACTIVE;
              pf_last[hit_at] = addr;
            end else if (pf_status[hit_at] == spt_pkg::ST_TRAINING) begin
              pf_last[hit_at] = addr;
              pf_stride[hit_at] = diff;
            end else begin
              pf_status[hit_at] = spt_pkg::ST_INVALID;
            end
          end
          r.hit = 1'b1;
          r.entry_index = spt_pkg::INDEX_W'(hit_at);
          r.entry_state = pf_status[hit_at];
        end
      end
      spt_pkg::OP_SEARCH: begin
        for (int i = 0; i < spt_pkg::ENTRIES; i++)
          if (hit_at < 0 && pf_tag[i] == pc && pf_status[i] == spt_pkg::ST_ACTIVE)
            hit_at = i;
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          r.entry_index = spt_pkg::INDEX_W'(hit_at);
          r.entry_state = spt_pkg::ST_ACTIVE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [spt_pkg::ADDR_WIDTH-1:0] pick_stride();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return spt_pkg::ADDR_WIDTH'($urandom_range(1, 16) * 4);
      2: return -spt_pkg::ADDR_WIDTH'($urandom_range(1, 16) * 4);
      3: return spt_pkg::ADDR_WIDTH'($urandom);
      default: return spt_pkg::ADDR_WIDTH'(64);
    endcase
  endfunction

  task automatic add_request(input spt_pkg::op_t op, input logic [spt_pkg::TAG_W-1:0] pc,
                             input logic [spt_pkg::IN_ADDR_W-1:0] address);
    request_t r;
    r.op = op;
    r.pc = pc;
    r.address = address;
    request_q.push_back(r);
  endtask

  // A typical access stream: open an entry, walk it with a fixed stride, then look it up.
  // Now and then one address breaks the stride or the opening allocate is missing.
  task automatic add_stream();
    logic [spt_pkg::TAG_W-1:0]      pc;
    logic [spt_pkg::ADDR_WIDTH-1:0] addr, stride;
    int n, break_at;
    pc = pc_pool[$urandom_range(0, POOL_SIZE - 1)];
    addr = spt_pkg::ADDR_WIDTH'($urandom);
    stride = pick_stride();
    n = $urandom_range(1, 5);
    break_at = ($urandom_range(0, 99) < 15) ? $urandom_range(1, n) : 0;
    if ($urandom_range(0, 9) != 0) add_request(spt_pkg::OP_ALLOC, pc, addr);
    for (int k = 1; k <= n; k++) begin
      addr = addr + stride;
      add_request(spt_pkg::OP_TRAIN, pc,
                  (k == break_at) ? spt_pkg::IN_ADDR_W'($urandom) : addr);
    end
    if ($urandom_range(0, 9) < 7) add_request(spt_pkg::OP_SEARCH, pc, $urandom);
  endtask

  // Stimulus, then the end of the run.
  initial begin
    logic [spt_pkg::IN_ADDR_W-1:0] a;
    for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
      pf_tag[i] = '0;
      pf_last[i] = '0;
      pf_stride[i] = '0;
      pf_status[i] = spt_pkg::ST_INVALID;
    end
    for (int i = 0; i < POOL_SIZE; i++) pc_pool[i] = $urandom;

    // Reset leaves tag zero in every entry, so a train on pc zero hits an invalid entry.
    add_request(spt_pkg::OP_TRAIN,  32'h0000_0000, 32'h0000_0005);
    add_request(spt_pkg::OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    add_request(spt_pkg::OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'h0000_0000);
    add_request(spt_pkg::OP_ALLOC,  32'hFFFF_FFFF, 32'hFFFF_FFF0);
    add_request(spt_pkg::OP_ALLOC,  32'hFFFF_FFFF, 32'h1234_5678);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'hFFFF_FFF0);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'h0000_0010);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'h0000_0010);
    add_request(spt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(spt_pkg::OP_ALLOC,  32'hFFFF_FFFF, 32'hFFFF_FFF0);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'h0000_0010);
    add_request(spt_pkg::OP_TRAIN,  32'hFFFF_FFFF, 32'h0000_0030);
    add_request(spt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(spt_pkg::OP_ALLOC,  32'hFFFF_FFFF, 32'h0000_0000);
    add_request(spt_pkg::OP_NONE,   32'h0000_0000, 32'h0000_0000);

    // Fill the table with active entries so that further allocates fall back to entry 0.
    for (int i = 0; i <= spt_pkg::ENTRIES; i++) begin
      a = $urandom;
      add_request(spt_pkg::OP_ALLOC, pc_pool[i], a);
      add_request(spt_pkg::OP_TRAIN, pc_pool[i], a);
    end

    while (request_q.size() < TARGET_ITEMS) begin
      if ($urandom_range(0, 99) < 85) add_stream();
      else add_request(spt_pkg::op_t'($urandom_range(0, 3)),
                       ($urandom_range(0, 1) != 0) ? pc_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : spt_pkg::TAG_W'($urandom),
                       $urandom);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (request_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Request driver: the expected reply is worked out as each beat is accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.op <= spt_pkg::OP_NONE;
      req_ch.pc <= '0;
      req_ch.address <= '0;
      send_wait <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        reply_q.push_back(table_lookup(spt_pkg::op_t'(req_ch.op), req_ch.pc, req_ch.address));
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        send_next = pick_gap(send_calm);
      end else begin
        send_next = send_wait;
      end
      if (send_next == 0 && request_q.size() != 0) begin
        beat = request_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= beat.op;
        req_ch.pc <= beat.pc;
        req_ch.address <= beat.address;
        send_wait <= 0;
      end else begin
        req_ch.valid <= 1'b0;
        send_wait <= (send_next > 0) ? send_next - 1 : 0;
      end
    end
  end

  // Response monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.hit = rsp_ch.hit;
        got.entry_index = rsp_ch.entry_index;
        got.entry_state = rsp_ch.entry_state;
        got.allocated = rsp_ch.allocated;
        recv_count <= recv_count + 1;
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: response %0d arrived with no request outstanding", recv_count);
        end else begin
          want = reply_q.pop_front();
          if (got.hit !== want.hit || got.entry_index !== want.entry_index ||
              got.entry_state !== want.entry_state || got.allocated !== want.allocated) begin
            errors++;
            if (errors <= 10) begin
              $display("tb: response %0d expected hit=%0b index=%0d state=%0d alloc=%0b",
                       recv_count, want.hit, want.entry_index, want.entry_state,
                       want.allocated);
              $display("tb: response %0d got      hit=%0b index=%0d state=%0d alloc=%0b",
                       recv_count, got.hit, got.entry_index, got.entry_state,
                       got.allocated);
            end
          end
        end
      end
      if (hold_on) begin
        rsp_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        recv_next = pick_gap(recv_calm);
        rsp_ch.ready <= (recv_next == 0);
        recv_wait <= (recv_next > 0) ? recv_next - 1 : 0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-offs so that the block backs up and stalls its request side.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_on <= 1'b0;
      hold_at <= 250;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_on <= (hold_left > 1);
    end else if (recv_count >= hold_at) begin
      hold_left <= 80;
      hold_on <= 1'b1;
      hold_at <= hold_at + 400;
    end
  end

endmodule
